// ===== hw/rtl/sha224c_pkg.sv =====
`timescale 1ns / 1ps

package sha224c_pkg;

  localparam int WORD_W     = 32;
  localparam int CHAIN_N    = 8;
  localparam int WINDOW_N   = 16;
  localparam int ROUNDS_N   = 64;
  localparam int CFG_IDX_W  = 4;
  localparam int POS_W      = 4;
  localparam int ROUND_W    = 6;
  localparam int EMIT_W     = 3;

  localparam logic [POS_W-1:0]   LAST_POS   = POS_W'(WINDOW_N - 1);
  localparam logic [ROUND_W-1:0] LAST_ROUND = ROUND_W'(ROUNDS_N - 1);
  localparam logic [EMIT_W-1:0]  LAST_EMIT  = EMIT_W'(CHAIN_N - 1);

  typedef logic [WORD_W-1:0] word_t;

  // SHA-224 initial chaining value.
  localparam word_t START_IV [CHAIN_N] = '{
    32'hc1059ed8, 32'h367cd507, 32'h3070dd17, 32'hf70e5939,
    32'hffc00b31, 32'h68581511, 32'h64f98fa7, 32'hbefa4fa4
  };

  // SHA-256 round constants.
  localparam word_t ROUND_K [ROUNDS_N] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_ROUND,
    ST_ADD,
    ST_EMIT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic                word_shift;
    logic                chain_reload;
    logic                work_load;
    logic                round_step;
    logic                chain_add;
    logic [ROUND_W-1:0]  round_idx;
    logic [EMIT_W-1:0]   emit_idx;
  } cmd_t;

  function automatic word_t big_sigma0(input word_t x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic word_t big_sigma1(input word_t x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic word_t small_sigma0(input word_t x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic word_t small_sigma1(input word_t x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

  function automatic word_t choose(input word_t e, input word_t f, input word_t g);
    return (e & f) ^ (~e & g);
  endfunction

  function automatic word_t majority(input word_t a, input word_t b, input word_t c);
    return (a & b) ^ (a & c) ^ (b & c);
  endfunction

endpackage

// ===== hw/rtl/sha224c_ctrl.sv =====
`timescale 1ns / 1ps

module sha224c_ctrl
  import sha224c_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_new_message,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [EMIT_W-1:0] out_digest_index,
  output logic              out_last_word,
  output cmd_t              cmd
);

  state_t             state_r, state_nxt;
  logic [POS_W-1:0]   pos_r, pos_nxt;
  logic [ROUND_W-1:0] round_r, round_nxt;
  logic [EMIT_W-1:0]  emit_r, emit_nxt;
  logic [POS_W-1:0]   eff_pos;

  // A new message restarts the block at word zero.
  assign eff_pos = in_new_message ? '0 : pos_r;

  // State and counter registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      pos_r   <= '0;
      round_r <= '0;
      emit_r  <= '0;
    end else begin
      state_r <= state_nxt;
      pos_r   <= pos_nxt;
      round_r <= round_nxt;
      emit_r  <= emit_nxt;
    end
  end

  // Next state, counters and datapath commands.
  always_comb begin
    state_nxt         = state_r;
    pos_nxt           = pos_r;
    round_nxt         = round_r;
    emit_nxt          = emit_r;
    in_ready          = 1'b0;
    out_valid         = 1'b0;
    cmd               = '0;
    cmd.round_idx     = round_r;
    cmd.emit_idx      = emit_r;
    unique case (state_r)
      ST_LOAD: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.word_shift   = 1'b1;
          cmd.chain_reload = in_new_message;
          pos_nxt          = eff_pos + 1'b1;
          if (eff_pos == LAST_POS) begin
            cmd.work_load = 1'b1;
            round_nxt     = '0;
            state_nxt     = ST_ROUND;
          end
        end
      end
      ST_ROUND: begin
        cmd.round_step = 1'b1;
        round_nxt      = round_r + 1'b1;
        if (round_r == LAST_ROUND) begin
          state_nxt = ST_ADD;
        end
      end
      ST_ADD: begin
        cmd.chain_add = 1'b1;
        emit_nxt      = '0;
        state_nxt     = ST_EMIT;
      end
      ST_EMIT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          emit_nxt = emit_r + 1'b1;
          if (emit_r == LAST_EMIT) begin
            state_nxt = ST_LOAD;
          end
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  assign out_digest_index = emit_r;
  assign out_last_word    = (emit_r == LAST_EMIT);

endmodule

// ===== hw/rtl/sha224c_datapath.sv =====
`timescale 1ns / 1ps

module sha224c_datapath
  import sha224c_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  cmd_t                 cmd,
  input  word_t                in_message_word,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  word_t                cfg_data,
  output word_t                out_digest_word
);

  word_t start_r  [CHAIN_N];
  word_t chain_r  [CHAIN_N];
  word_t work_r   [CHAIN_N];
  word_t window_r [WINDOW_N];

  word_t sched_new;
  word_t t1;
  word_t t2;

  // Start registers: writes to indices 8 and above are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHAIN_N; i++) begin
        start_r[i] <= START_IV[i];
      end
    end else if (cfg_write && (cfg_index < CFG_IDX_W'(CHAIN_N))) begin
      start_r[cfg_index[EMIT_W-1:0]] <= cfg_data;
    end
  end

  // Chaining value: reloaded on a new message, accumulated after the rounds.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHAIN_N; i++) begin
        chain_r[i] <= START_IV[i];
      end
    end else if (cmd.chain_reload) begin
      for (int i = 0; i < CHAIN_N; i++) begin
        chain_r[i] <= start_r[i];
      end
    end else if (cmd.chain_add) begin
      for (int i = 0; i < CHAIN_N; i++) begin
        chain_r[i] <= chain_r[i] + work_r[i];
      end
    end
  end

  // Next schedule word from the sliding sixteen-word window.
  assign sched_new = small_sigma1(window_r[14]) + window_r[9]
                   + small_sigma0(window_r[1]) + window_r[0];

  // Schedule window: message words shift in while loading, expanded words
  // during the rounds. The oldest entry is the current round's word.
  always_ff @(posedge clk) begin
    if (cmd.word_shift || cmd.round_step) begin
      for (int i = 0; i < WINDOW_N - 1; i++) begin
        window_r[i] <= window_r[i+1];
      end
      window_r[WINDOW_N-1] <= cmd.word_shift ? in_message_word : sched_new;
    end
  end

  // Round function terms.
  assign t1 = work_r[7] + big_sigma1(work_r[4]) + choose(work_r[4], work_r[5], work_r[6])
            + ROUND_K[cmd.round_idx] + window_r[0];
  assign t2 = big_sigma0(work_r[0]) + majority(work_r[0], work_r[1], work_r[2]);

  // Working words a to h: one round per cycle.
  always_ff @(posedge clk) begin
    if (cmd.work_load) begin
      for (int i = 0; i < CHAIN_N; i++) begin
        work_r[i] <= chain_r[i];
      end
    end else if (cmd.round_step) begin
      work_r[0] <= t1 + t2;
      work_r[1] <= work_r[0];
      work_r[2] <= work_r[1];
      work_r[3] <= work_r[2];
      work_r[4] <= work_r[3] + t1;
      work_r[5] <= work_r[4];
      work_r[6] <= work_r[5];
      work_r[7] <= work_r[6];
    end
  end

  assign out_digest_word = chain_r[cmd.emit_idx];

endmodule

// ===== hw/rtl/sha224_block_compression_top.sv =====
`timescale 1ns / 1ps

// SHA-224 block compression. Message words enter one beat at a time; every
// sixteenth word (counted from the last beat with in_new_message set, which
// also reloads the chain from the start registers) closes a block. The block
// then runs 64 rounds at one round per cycle on a single shared round unit,
// an add state folds the result into the chaining value, and eight result beats
// follow carrying chaining words 0 to 7, the last flagged by out_last_word.
// No input is taken during the rounds, the add or while results are being
// delivered, so the next block's words wait until the last result beat is taken.
// The start registers (indices 0 to 7) reset to the SHA-224 initial value,
// take effect at the next new message, and should be written while idle.
module sha224_block_compression_top
  import sha224c_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [31:0]          in_message_word,
  input  logic                 in_new_message,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [2:0]           out_digest_index,
  output logic [31:0]          out_digest_word,
  output logic                 out_last_word,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);

  cmd_t cmd;

  // Configuration beats are always taken.
  assign cfg_ready = 1'b1;

  sha224c_ctrl u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_new_message   (in_new_message),
    .in_ready         (in_ready),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_digest_index (out_digest_index),
    .out_last_word    (out_last_word),
    .cmd              (cmd)
  );

  sha224c_datapath u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .in_message_word (in_message_word),
    .cfg_write       (cfg_valid),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .out_digest_word (out_digest_word)
  );

endmodule

// ===== tb/tb_sha224_block_compression_top.sv =====
`timescale 1ns / 1ps

module tb_sha224_block_compression_top;
  import sha224c_pkg::*;

  localparam int N_CHAIN         = 8;
  localparam int N_WINDOW        = 16;
  localparam int N_ROUNDS        = 64;
  localparam int START_REG0      = 0;
  localparam int FIRST_SPARE_REG = 8;
  localparam int N_REG_CODES     = 16;
  localparam int LAST_SLOT       = 7;
  localparam int DRAIN_CYCLES    = 100;
  localparam int STALL_LIMIT     = 2000;

  // Chaining value of SHA-224 before any block.
  localparam word_t SHA224_IV [N_CHAIN] = '{
    32'hc1059ed8, 32'h367cd507, 32'h3070dd17, 32'hf70e5939,
    32'hffc00b31, 32'h68581511, 32'h64f98fa7, 32'hbefa4fa4
  };

  // SHA-256 round constants.
  localparam word_t RK [N_ROUNDS] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  // Edge patterns for the opening block, which carries no new-message flag.
  localparam word_t EDGE_WORDS [N_WINDOW] = '{
    32'h00000000, 32'hffffffff, 32'h80000000, 32'h00000001,
    32'haaaaaaaa, 32'h55555555, 32'h7fffffff, 32'hfffffffe,
    32'h61626380, 32'h00000000, 32'hffffffff, 32'h0000ffff,
    32'hffff0000, 32'h00000000, 32'h00000000, 32'h00000018
  };

  typedef struct packed {
    word_t word;
    logic  fresh;
  } msg_beat_t;

  typedef struct packed {
    logic [2:0] slot;
    word_t      value;
    logic       last_flag;
  } digest_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [31:0]          in_message_word = '0;
  logic                 in_new_message = 1'b0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [2:0]           out_digest_index;
  logic [31:0]          out_digest_word;
  logic                 out_last_word;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0]          cfg_data = '0;

  sha224_block_compression_top dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_message_word  (in_message_word),
    .in_new_message   (in_new_message),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_digest_index (out_digest_index),
    .out_digest_word  (out_digest_word),
    .out_last_word    (out_last_word),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Predictor state: start registers, chain, schedule window, fill position.
  word_t          start_regs [N_CHAIN];
  word_t          chain [N_CHAIN];
  word_t          msg_window [N_WINDOW];
  logic [3:0]     fill_pos;

  msg_beat_t      word_q [$];
  digest_t        digest_q [$];
  int             errors = 0;
  bit             send_calm = 1'b0;
  bit             recv_calm = 1'b0;

  function automatic word_t ror32(word_t x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic word_t sum0(word_t x);
    return ror32(x, 2) ^ ror32(x, 13) ^ ror32(x, 22);
  endfunction

  function automatic word_t sum1(word_t x);
    return ror32(x, 6) ^ ror32(x, 11) ^ ror32(x, 25);
  endfunction

  function automatic word_t mix0(word_t x);
    return ror32(x, 7) ^ ror32(x, 18) ^ (x >> 3);
  endfunction

  function automatic word_t mix1(word_t x);
    return ror32(x, 17) ^ ror32(x, 19) ^ (x >> 10);
  endfunction

  // Expand the window, run the 64 rounds and fold them into the chain.
  function automatic void compress_block();
    word_t sched [N_ROUNDS];
    word_t v [N_CHAIN];
    word_t t1, t2;
    for (int t = 0; t < N_WINDOW; t++) sched[t] = msg_window[t];
    for (int t = N_WINDOW; t < N_ROUNDS; t++)
      sched[t] = mix1(sched[t-2]) + sched[t-7] + mix0(sched[t-15]) + sched[t-16];
    v = chain;
    for (int t = 0; t < N_ROUNDS; t++) begin
      t1 = v[7] + sum1(v[4]) + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RK[t] + sched[t];
      t2 = sum0(v[0]) + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6];
      v[6] = v[5];
      v[5] = v[4];
      v[4] = v[3] + t1;
      v[3] = v[2];
      v[2] = v[1];
      v[1] = v[0];
      v[0] = t1 + t2;
    end
    for (int k = 0; k < N_CHAIN; k++) chain[k] = chain[k] + v[k];
  endfunction

  // Take one accepted message word; a completed block yields eight digest beats.
  function automatic void absorb_word(msg_beat_t b);
    if (b.fresh) begin
      chain = start_regs;
      fill_pos = '0;
    end
    msg_window[fill_pos] = b.word;
    fill_pos = fill_pos + 4'd1;
    if (fill_pos == '0) begin
      compress_block();
      for (int k = 0; k < N_CHAIN; k++)
        digest_q.push_back('{slot: 3'(k), value: chain[k], last_flag: (k == LAST_SLOT)});
    end
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic word_t pick_word();
    case ($urandom_range(0, 15))
      0: return '0;
      1: return '1;
      2: return word_t'(1) << $urandom_range(0, 31);
      default: return $urandom();
    endcase
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("[%0t] mismatch: %s got %h want %h", $realtime, what, got, want);
    errors++;
  endtask

  // Message driver: one beat in flight, random hold-off after each acceptance outside calm spells.
  always @(posedge clk) begin : word_driver
    msg_beat_t cur;
    int        send_hold;
    bit        busy;
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_hold = 0;
    end else begin
      busy = in_valid;
      if (in_valid && in_ready) begin
        absorb_word(cur);
        busy = 1'b0;
        send_hold = send_calm ? 0 : pick_gap();
        if ($urandom_range(0, 39) == 0) send_calm = !send_calm;
      end
      if (!busy) begin
        if (send_hold > 0) begin
          send_hold--;
        end else if (word_q.size() > 0) begin
          cur = word_q.pop_front();
          in_message_word <= cur.word;
          in_new_message <= cur.fresh;
          busy = 1'b1;
        end
      end
      in_valid <= busy;
    end
  end

  // Digest monitor: checks each beat against the oldest expectation.
  always @(posedge clk) begin : digest_monitor
    digest_t want;
    int      recv_stall;
    bit      ready_nxt;
    if (!rst_n) begin
      out_ready <= 1'b0;
      recv_stall = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (digest_q.size() == 0) begin
          report_mismatch("digest beat with nothing pending", out_digest_word, '0);
        end else begin
          want = digest_q.pop_front();
          if (out_digest_index !== want.slot)
            report_mismatch("digest_index", 32'(out_digest_index), 32'(want.slot));
          if (out_digest_word !== want.value)
            report_mismatch("digest_word", out_digest_word, want.value);
          if (out_last_word !== want.last_flag)
            report_mismatch("last_word", 32'(out_last_word), 32'(want.last_flag));
        end
      end
      if (recv_stall > 0) begin
        recv_stall--;
        ready_nxt = 1'b0;
      end else begin
        ready_nxt = 1'b1;
        if (!recv_calm && $urandom_range(0, 4) == 0) recv_stall = pick_gap();
      end
      if ($urandom_range(0, 63) == 0) recv_calm = !recv_calm;
      out_ready <= ready_nxt;
    end
  end

  // One register write; the predictor copy follows the accepted beat.
  task automatic write_reg(int idx, word_t data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_IDX_W'(idx);
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx < START_REG0 + N_CHAIN) start_regs[idx - START_REG0] = data;
    cfg_valid <= 1'b0;
  endtask

  // Wait until every queued word is taken and every digest has arrived. The
  // check is made at the falling edge, once the driver's updates have settled.
  task automatic settle();
    do @(negedge clk); while (word_q.size() != 0 || in_valid || digest_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Mostly whole messages of one to three blocks, plus cut-short messages and
  // unflagged blocks that carry on from whatever chain is held.
  task automatic queue_traffic(int n);
    int added;
    int kind;
    int len;
    added = 0;
    while (added < n) begin
      kind = $urandom_range(0, 19);
      if (kind < 14) len = N_WINDOW * (($urandom_range(0, 3) == 0) ? $urandom_range(2, 3) : 1);
      else if (kind < 17) len = $urandom_range(1, N_WINDOW - 1);
      else len = N_WINDOW;
      for (int i = 0; i < len; i++)
        word_q.push_back('{word: pick_word(), fresh: (i == 0 && kind < 17)});
      added += len;
    end
  endtask

  // Stall watchdog: returns once nothing has been accepted for too long.
  task automatic watch_stalls();
    int idle;
    idle = 0;
    while (idle < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        idle = 0;
      else
        idle++;
    end
  endtask

  task automatic run_phases();
    word_t fill;
    start_regs = SHA224_IV;
    chain = SHA224_IV;
    msg_window = '{default: '0};
    fill_pos = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Opening block without the new-message flag, then a message cut short.
    for (int i = 0; i < N_WINDOW; i++) word_q.push_back('{word: EDGE_WORDS[i], fresh: 1'b0});
    word_q.push_back('{word: 32'hffffffff, fresh: 1'b1});
    word_q.push_back('{word: 32'h00000000, fresh: 1'b0});
    word_q.push_back('{word: 32'h80000001, fresh: 1'b0});
    word_q.push_back('{word: 32'h12345678, fresh: 1'b0});
    queue_traffic(70);
    settle();

    // Four register settings: all zero, all one, random, back to SHA-224.
    for (int phase = 0; phase < 4; phase++) begin
      for (int i = 0; i < N_CHAIN; i++) begin
        case (phase)
          0: fill = '0;
          1: fill = '1;
          2: fill = $urandom();
          default: fill = SHA224_IV[i];
        endcase
        write_reg(START_REG0 + i, fill);
      end
      if (phase == 0)
        for (int i = FIRST_SPARE_REG; i < N_REG_CODES; i++) write_reg(i, $urandom());
      // An unflagged block first: the written registers must not touch the chain.
      for (int i = 0; i < N_WINDOW; i++) word_q.push_back('{word: pick_word(), fresh: 1'b0});
      queue_traffic(phase == 3 ? 55 : 60);
      settle();
    end
  endtask

  initial begin
    bit timed_out;
    timed_out = 1'b0;
    fork
      run_phases();
      begin
        watch_stalls();
        timed_out = 1'b1;
      end
    join_any
    if (!timed_out && errors == 0 && digest_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
